// ===== hdl/shpt_pkg.sv =====
// Shared constants, types and helper functions for the step/heading path tracker.
package shpt_pkg;

	// Default width of the wrapping x,y position counters
	localparam int POSITION_BITS_DEF = 8;

	// Yaw is kept in units of 1e-5 degree
	localparam logic [25:0] FULL_TURN   = 26'd36000000;
	localparam logic [25:0] SECTOR_SPAN = 26'd4500000;
	localparam logic [25:0] HALF_SECTOR = 26'd2250000;

	// Configuration reset values
	localparam logic signed [23:0] STEP_THRESHOLD_RST = -24'sd75000;
	localparam logic [22:0]        YAW_DEADBAND_RST   = 23'd5000;

	// Configuration register indexes
	typedef enum logic {
		REG_STEP_THRESHOLD = 1'b0,
		REG_YAW_DEADBAND   = 1'b1
	} cfg_reg_t;

	// Input item opcodes
	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	// Control from the step logic to the heading datapath
	typedef struct packed {
		logic snap;       // step completed: quantize and snap yaw first
		logic integrate;  // run one trapezoid step on the x rate
	} trk_ctrl_t;

	// One-unit move in a sector direction: -1, 0 or +1
	typedef logic signed [1:0] move_t;

	// Quantize yaw to one of eight sectors; each sector includes its upper edge
	function automatic logic [2:0] heading_sector(input logic [25:0] yaw);
		logic [2:0] sec;
		sec = 3'd7;
		for (int k = 6; k >= 1; k--) begin
			if (yaw <= 26'(HALF_SECTOR + SECTOR_SPAN * k)) begin
				sec = 3'(k);
			end
		end
		if (yaw <= HALF_SECTOR || yaw > (FULL_TURN - HALF_SECTOR)) begin
			sec = 3'd0;
		end
		return sec;
	endfunction

	// Yaw at the center of a sector
	function automatic logic [25:0] sector_center(input logic [2:0] sec);
		return 26'(SECTOR_SPAN * {23'd0, sec});
	endfunction

	// East component of a sector direction (north is sector 0, clockwise)
	function automatic move_t move_dx(input logic [2:0] sec);
		move_t d;
		unique case (sec)
			3'd1, 3'd2, 3'd3: d = 2'sd1;
			3'd5, 3'd6, 3'd7: d = -2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

	// North component of a sector direction
	function automatic move_t move_dy(input logic [2:0] sec);
		move_t d;
		unique case (sec)
			3'd7, 3'd0, 3'd1: d = 2'sd1;
			3'd3, 3'd4, 3'd5: d = -2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/shpt_heading.sv =====
// Heading datapath: sector quantization, yaw snap, trapezoid yaw integration and wrap.
module shpt_heading (
	input  logic [25:0]        yaw_cur,
	input  logic signed [23:0] last_rate,
	input  logic signed [23:0] rate_x,
	input  logic [22:0]        yaw_deadband,
	input  shpt_pkg::trk_ctrl_t ctrl,
	output logic [2:0]         sector_new,
	output logic [25:0]        yaw_next
);

	logic [25:0]        yaw_base;
	logic signed [24:0] rate_sum;
	logic signed [24:0] rate_sum_adj;
	logic signed [23:0] half;
	logic [23:0]        half_mag;
	logic signed [26:0] yaw_sum;
	logic [25:0]        yaw_wrap;

	// Sector from the yaw held before this sample; snap yaw to its center on a step
	assign sector_new = shpt_pkg::heading_sector(yaw_cur);
	assign yaw_base   = ctrl.snap ? shpt_pkg::sector_center(sector_new) : yaw_cur;

	// Half-sum of the two newest x rates, truncated toward zero
	assign rate_sum     = {last_rate[23], last_rate} + {rate_x[23], rate_x};
	assign rate_sum_adj = rate_sum + {24'd0, rate_sum[24] & rate_sum[0]};
	assign half         = rate_sum_adj[24:1];
	assign half_mag     = half[23] ? 24'(-half) : half;

	// Add to yaw and wrap into 0..FULL_TURN (exactly FULL_TURN is kept)
	always_comb begin
		yaw_sum = $signed({1'b0, yaw_base}) + {{3{half[23]}}, half};
		if (yaw_sum[26]) begin
			yaw_wrap = 26'(yaw_sum + $signed({1'b0, shpt_pkg::FULL_TURN}));
		end else if (yaw_sum > $signed({1'b0, shpt_pkg::FULL_TURN})) begin
			yaw_wrap = 26'(yaw_sum - $signed({1'b0, shpt_pkg::FULL_TURN}));
		end else begin
			yaw_wrap = yaw_sum[25:0];
		end
	end

	// Integrate only above the deadband
	assign yaw_next = (ctrl.integrate && (half_mag > {1'b0, yaw_deadband})) ? yaw_wrap
	                                                                          : yaw_base;

endmodule

// ===== hdl/step_heading_path_tracker_unit.sv =====
// Top level of the step/heading path tracker: step detection, state and result buffering.
//
// Accepts one transaction per clock while in_ready is high (a gyro sample or a restart)
// and returns exactly one result per transaction. All work for an item is done in a single
// pass of combinational logic from the accepted input and the tracker state into the state
// registers and the result register, so a sustained rate of one item per cycle holds while
// the consumer keeps taking results. Results pass through a result register backed by a skid
// register; in_ready drops only when both hold results the consumer has not yet taken.
// Configuration writes take effect on the next clock and must be made while idle.
module step_heading_path_tracker_unit #(
	parameter int POSITION_BITS = shpt_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [0:0]         op,
	input  logic signed [23:0] rate_z,
	input  logic signed [23:0] rate_x,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [0:0]         step_seen,
	output logic [15:0]        steps_total,
	output logic signed [7:0]  pos_x,
	output logic signed [7:0]  pos_y,
	output logic [2:0]         sector,
	output logic [25:0]        heading
);

	typedef struct packed {
		logic        seen;
		logic [15:0] total;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [2:0]  sec;
		logic [25:0] yaw;
	} result_t;

	// configuration
	logic signed [23:0] step_threshold_q;
	logic [22:0]        yaw_deadband_q;

	// tracker state
	logic                     armed_q;
	logic [15:0]              step_count_q;
	logic [25:0]              yaw_q;
	logic signed [23:0]       last_rate_q;
	logic [POSITION_BITS-1:0] x_pos_q;
	logic [POSITION_BITS-1:0] y_pos_q;
	logic [2:0]               sector_q;

	// next state
	logic                     armed_d;
	logic [15:0]              step_count_d;
	logic [25:0]              yaw_d;
	logic signed [23:0]       last_rate_d;
	logic [POSITION_BITS-1:0] x_pos_d;
	logic [POSITION_BITS-1:0] y_pos_d;
	logic [2:0]               sector_d;
	logic                     seen_d;

	logic                     is_restart;
	logic                     arm;
	logic                     step;
	shpt_pkg::trk_ctrl_t      ctrl;
	logic [2:0]               sector_new;
	logic [25:0]              yaw_next;
	shpt_pkg::move_t          dx;
	shpt_pkg::move_t          dy;
	logic [POSITION_BITS+7:0] x_ext;
	logic [POSITION_BITS+7:0] y_ext;

	// result buffering
	result_t res_d;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    in_fire;
	logic    out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign in_ready = !skid_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_threshold_q <= shpt_pkg::STEP_THRESHOLD_RST;
			yaw_deadband_q   <= shpt_pkg::YAW_DEADBAND_RST;
		end else if (cfg_we) begin
			unique case (shpt_pkg::cfg_reg_t'(cfg_index))
				shpt_pkg::REG_STEP_THRESHOLD: step_threshold_q <= cfg_data;
				shpt_pkg::REG_YAW_DEADBAND:   yaw_deadband_q   <= cfg_data[22:0];
			endcase
		end
	end

	// step detection
	assign is_restart = (shpt_pkg::op_t'(op) == shpt_pkg::OP_RESTART);
	assign arm        = !is_restart && !armed_q && (rate_z < step_threshold_q);
	assign step       = !is_restart && !arm && armed_q && (rate_z > step_threshold_q);
	assign ctrl.snap      = step;
	assign ctrl.integrate = !is_restart && !arm;

	shpt_heading u_heading (
		.yaw_cur      (yaw_q),
		.last_rate    (last_rate_q),
		.rate_x       (rate_x),
		.yaw_deadband (yaw_deadband_q),
		.ctrl         (ctrl),
		.sector_new   (sector_new),
		.yaw_next     (yaw_next)
	);

	assign dx = shpt_pkg::move_dx(sector_new);
	assign dy = shpt_pkg::move_dy(sector_new);

	// next tracker state
	always_comb begin
		armed_d      = armed_q;
		step_count_d = step_count_q;
		yaw_d        = yaw_q;
		last_rate_d  = last_rate_q;
		x_pos_d      = x_pos_q;
		y_pos_d      = y_pos_q;
		sector_d     = sector_q;
		seen_d       = 1'b0;
		priority if (is_restart) begin
			yaw_d       = '0;
			last_rate_d = '0;
			x_pos_d     = '0;
			y_pos_d     = '0;
			sector_d    = '0;
		end else if (arm) begin
			armed_d = 1'b1;
		end else begin
			if (step) begin
				armed_d      = 1'b0;
				step_count_d = step_count_q + 16'd1;
				seen_d       = 1'b1;
				sector_d     = sector_new;
				x_pos_d      = x_pos_q + {{(POSITION_BITS-2){dx[1]}}, dx};
				y_pos_d      = y_pos_q + {{(POSITION_BITS-2){dy[1]}}, dy};
			end
			last_rate_d = rate_x;
			yaw_d       = yaw_next;
		end
	end

	// result for this transaction; position shows its low eight bits
	assign x_ext = {8'd0, x_pos_d};
	assign y_ext = {8'd0, y_pos_d};
	always_comb begin
		res_d.seen  = seen_d;
		res_d.total = step_count_d;
		res_d.px    = x_ext[7:0];
		res_d.py    = y_ext[7:0];
		res_d.sec   = sector_d;
		res_d.yaw   = yaw_d;
	end

	// tracker state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			step_count_q <= '0;
			yaw_q        <= '0;
			last_rate_q  <= '0;
			x_pos_q      <= '0;
			y_pos_q      <= '0;
			sector_q     <= '0;
		end else if (in_fire) begin
			armed_q      <= armed_d;
			step_count_q <= step_count_d;
			yaw_q        <= yaw_d;
			last_rate_q  <= last_rate_d;
			x_pos_q      <= x_pos_d;
			y_pos_q      <= y_pos_d;
			sector_q     <= sector_d;
		end
	end

	// result and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_fire) begin
				if (out_valid_q && !out_ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign step_seen   = out_q.seen;
	assign steps_total = out_q.total;
	assign pos_x       = out_q.px;
	assign pos_y       = out_q.py;
	assign sector      = out_q.sec;
	assign heading     = out_q.yaw;

endmodule

// ===== hdl/shpt_checker.sv =====
// Port-level assertions for the path tracker top level, with the bind that attaches them.
module shpt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [0:0]         step_seen,
	input logic [15:0]        steps_total,
	input logic signed [7:0]  pos_x,
	input logic signed [7:0]  pos_y,
	input logic [2:0]         sector,
	input logic [25:0]        heading
);

	logic [15:0] total_q;
	logic        out_fire;

	assign out_fire = out_valid && out_ready;

	// step count of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (out_fire) begin
			total_q <= steps_total;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steps_total) && $stable(heading)
		&& $stable(pos_x) && $stable(pos_y) && $stable(sector) && $stable(step_seen))
		else $error("result changed while stalled");

	// input backpressure only while results are waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// heading stays within one full turn
	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading <= 26'd36000000)
		else $error("heading out of range");

	// step count advances by one exactly on a completed step
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (steps_total == (step_seen[0] ? 16'(total_q + 16'd1) : total_q)))
		else $error("step count inconsistent with step flag");

endmodule

bind step_heading_path_tracker_unit shpt_checker u_shpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.step_seen   (step_seen),
	.steps_total (steps_total),
	.pos_x       (pos_x),
	.pos_y       (pos_y),
	.sector      (sector),
	.heading     (heading)
);

// ===== tb/step_track_checker.sv =====
// Checker for the step/heading path tracker: watches both channels, predicts and compares.
module step_track_checker #(
	parameter int POS_BITS = shpt_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [0:0]         op,
	input  logic signed [23:0] rate_z,
	input  logic signed [23:0] rate_x,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [0:0]         step_seen,
	input  logic [15:0]        steps_total,
	input  logic signed [7:0]  pos_x,
	input  logic signed [7:0]  pos_y,
	input  logic [2:0]         sector,
	input  logic [25:0]        heading,
	output int                 mismatch_count,
	output int                 results_owed
);

	// yaw units are 1e-5 degree
	localparam int TURN     = 36000000;
	localparam int ARC      = 4500000;
	localparam int HALF_ARC = 2250000;

	typedef struct packed {
		logic        step_seen;
		logic [15:0] steps;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [2:0]  sec;
		logic [25:0] head;
	} track_rec_t;

	// register copies
	logic signed [23:0] thresh;
	logic [22:0]        dead;

	// tracker state
	logic                armed_q;
	logic [15:0]         step_cnt;
	int                  yaw;
	int                  x_new;
	int                  x_old;
	logic [POS_BITS-1:0] east;
	logic [POS_BITS-1:0] north;
	logic [2:0]          last_sec;

	// results owed by the block, oldest first
	track_rec_t owed_q[$];

	// each sector includes its upper edge; the top half sector wraps to north
	function automatic logic [2:0] sector_of(input int y);
		if (y <= HALF_ARC || y > TURN - HALF_ARC) begin
			return 3'd0;
		end
		return 3'((y - HALF_ARC - 1) / ARC + 1);
	endfunction

	// advance the tracker by one transaction and form its result
	task automatic track_item(input shpt_pkg::op_t o, input logic signed [23:0] rz,
			input logic signed [23:0] rx, output track_rec_t r);
		int half;
		int mag;
		r = '0;
		if (o == shpt_pkg::OP_RESTART) begin
			yaw = 0;
			x_new = 0;
			x_old = 0;
			east = '0;
			north = '0;
			last_sec = 3'd0;
		end else if (rz < thresh && !armed_q) begin
			// arming sample: no history shift, yaw untouched
			armed_q = 1'b1;
		end else begin
			if (armed_q && rz > thresh) begin
				armed_q = 1'b0;
				step_cnt = step_cnt + 16'd1;
				r.step_seen = 1'b1;
				last_sec = sector_of(yaw);
				yaw = ARC * int'(last_sec);
				case (last_sec)
					3'd1, 3'd2, 3'd3: east = east + 1'b1;
					3'd5, 3'd6, 3'd7: east = east - 1'b1;
					default: ;
				endcase
				case (last_sec)
					3'd7, 3'd0, 3'd1: north = north + 1'b1;
					3'd3, 3'd4, 3'd5: north = north - 1'b1;
					default: ;
				endcase
			end
			// trapezoid step on the x rate, truncated toward zero
			x_old = x_new;
			x_new = int'(rx);
			half = (x_old + x_new) / 2;
			mag = (half < 0) ? -half : half;
			if (mag > int'(dead)) begin
				yaw = yaw + half;
				if (yaw < 0) begin
					yaw = yaw + TURN;
				end
				if (yaw > TURN) begin
					yaw = yaw - TURN;
				end
			end
		end
		r.steps = step_cnt;
		r.px = 8'(east);
		r.py = 8'(north);
		r.sec = last_sec;
		r.head = 26'(yaw);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// compare results, then predict new transactions, then apply register writes
	always @(posedge clk or negedge arst_n) begin
		track_rec_t want;
		if (!arst_n) begin
			thresh = shpt_pkg::STEP_THRESHOLD_RST;
			dead = shpt_pkg::YAW_DEADBAND_RST;
			armed_q = 1'b0;
			step_cnt = '0;
			yaw = 0;
			x_new = 0;
			x_old = 0;
			east = '0;
			north = '0;
			last_sec = 3'd0;
			owed_q.delete();
			mismatch_count = 0;
			results_owed = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("result with nothing owed", 1, 0);
				end else begin
					want = owed_q.pop_front();
					if (step_seen !== want.step_seen)
						report_mismatch("step_seen", step_seen, want.step_seen);
					if (steps_total !== want.steps)
						report_mismatch("steps_total", steps_total, want.steps);
					if (pos_x !== want.px)
						report_mismatch("pos_x", pos_x, $signed(want.px));
					if (pos_y !== want.py)
						report_mismatch("pos_y", pos_y, $signed(want.py));
					if (sector !== want.sec)
						report_mismatch("sector", sector, want.sec);
					if (heading !== want.head)
						report_mismatch("heading", heading, want.head);
				end
			end
			if (in_valid && in_ready) begin
				track_item(shpt_pkg::op_t'(op), rate_z, rate_x, want);
				owed_q.push_back(want);
			end
			if (cfg_we) begin
				case (shpt_pkg::cfg_reg_t'(cfg_index))
					shpt_pkg::REG_STEP_THRESHOLD: thresh = cfg_data;
					shpt_pkg::REG_YAW_DEADBAND:   dead = cfg_data[22:0];
					default: ;
				endcase
			end
			results_owed = owed_q.size();
		end
	end

endmodule

// ===== tb/step_heading_path_tracker_unit_tb.sv =====
// Testbench top for the step/heading path tracker: stimulus, idling and the verdict.
module step_heading_path_tracker_unit_tb;

	localparam int RATE_MIN = -8388608;
	localparam int RATE_MAX = 8388607;
	localparam int DEAD_MAX = 8388607;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [0:0]         op;
	logic signed [23:0] rate_z;
	logic signed [23:0] rate_x;
	logic               out_valid;
	logic               out_ready;
	logic [0:0]         step_seen;
	logic [15:0]        steps_total;
	logic signed [7:0]  pos_x;
	logic signed [7:0]  pos_y;
	logic [2:0]         sector;
	logic [25:0]        heading;
	int                 mismatch_count;
	int                 results_owed;

	// settings the random stimulus aims at
	int   cur_thr;
	int   cur_db;

	step_heading_path_tracker_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.rate_z     (rate_z),
		.rate_x     (rate_x),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.step_seen  (step_seen),
		.steps_total(steps_total),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.sector     (sector),
		.heading    (heading)
	);

	step_track_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.rate_z        (rate_z),
		.rate_x        (rate_x),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.step_seen     (step_seen),
		.steps_total   (steps_total),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.sector        (sector),
		.heading       (heading),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// one input transaction, with a random gap ahead of it
	task automatic send_item(input shpt_pkg::op_t o, input int rz, input int rx);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		rate_z = 24'(rz);
		rate_x = 24'(rx);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// register write once every owed result has come back
	task automatic program_reg(input shpt_pkg::cfg_reg_t r, input logic [23:0] v);
		in_valid = 1'b0;
		while (results_owed != 0) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// deadband writes carry a random bit 23, which the block drops
	task automatic set_config(input int thr, input int db);
		program_reg(shpt_pkg::REG_STEP_THRESHOLD, 24'(thr));
		program_reg(shpt_pkg::REG_YAW_DEADBAND, {1'($urandom), 23'(db)});
		cur_thr = thr;
		cur_db = db;
	endtask

	// z rates mostly just below or above the threshold so steps keep coming
	task automatic send_random();
		int pick;
		int rz;
		int rx;
		shpt_pkg::op_t o;
		o = ($urandom_range(0, 39) == 0) ? shpt_pkg::OP_RESTART : shpt_pkg::OP_SAMPLE;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			rz = cur_thr - int'($urandom_range(1, 3000));
			if (rz < RATE_MIN) rz = RATE_MIN;
		end else if (pick < 80) begin
			rz = cur_thr + int'($urandom_range(1, 3000));
			if (rz > RATE_MAX) rz = RATE_MAX;
		end else if (pick < 85) begin
			rz = cur_thr;
		end else begin
			rz = int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN;
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			rx = int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN;
		end else if (pick < 70) begin
			// around the deadband edge
			rx = int'($urandom_range(0, 4 * cur_db + 8)) - 2 * cur_db - 4;
		end else begin
			rx = int'($urandom_range(0, 4000000)) - 2000000;
		end
		send_item(o, rz, rx);
	endtask

	// result side: random stall before each transaction
	initial begin
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, 4);
			if (hold > 0) begin
				out_ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = shpt_pkg::OP_SAMPLE;
		rate_z = '0;
		rate_x = '0;
		cur_thr = int'(shpt_pkg::STEP_THRESHOLD_RST);
		cur_db = int'(shpt_pkg::YAW_DEADBAND_RST);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: field extremes, threshold equality, restart with junk rates
		send_item(shpt_pkg::OP_SAMPLE, 0, 0);
		send_item(shpt_pkg::OP_SAMPLE, RATE_MIN, RATE_MAX);
		send_item(shpt_pkg::OP_SAMPLE, cur_thr, RATE_MIN);
		send_item(shpt_pkg::OP_SAMPLE, RATE_MAX, RATE_MAX);
		send_item(shpt_pkg::OP_RESTART, RATE_MIN, RATE_MAX);

		// zero deadband: exact sector edges and exact full turn
		set_config(0, 0);
		send_item(shpt_pkg::OP_RESTART, RATE_MAX, RATE_MIN);
		send_item(shpt_pkg::OP_SAMPLE, 1, 4500000);
		send_item(shpt_pkg::OP_SAMPLE, -1, 0);
		send_item(shpt_pkg::OP_SAMPLE, 1, -4500000);
		send_item(shpt_pkg::OP_RESTART, 0, 0);
		send_item(shpt_pkg::OP_SAMPLE, 1, 4500002);
		send_item(shpt_pkg::OP_SAMPLE, -1, 0);
		send_item(shpt_pkg::OP_SAMPLE, 1, 0);
		send_item(shpt_pkg::OP_RESTART, 0, 0);
		repeat (5) send_item(shpt_pkg::OP_SAMPLE, 1, 8000000);
		send_item(shpt_pkg::OP_SAMPLE, -1, 0);
		send_item(shpt_pkg::OP_SAMPLE, 1, 8000000);
		send_item(shpt_pkg::OP_SAMPLE, 1, -2);

		// lowest threshold can never arm; top deadband integrates only when both x rates are at the lowest value
		set_config(RATE_MIN, DEAD_MAX);
		send_item(shpt_pkg::OP_SAMPLE, RATE_MIN, RATE_MIN);
		send_item(shpt_pkg::OP_SAMPLE, RATE_MAX, RATE_MAX);
		// highest threshold arms but never completes
		set_config(RATE_MAX, 0);
		send_item(shpt_pkg::OP_SAMPLE, 0, RATE_MAX);
		send_item(shpt_pkg::OP_SAMPLE, RATE_MAX, RATE_MIN);

		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0) begin
				set_config(int'(shpt_pkg::STEP_THRESHOLD_RST),
					int'(shpt_pkg::YAW_DEADBAND_RST));
			end else if (ph == 3) begin
				set_config(int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN,
					$urandom_range(0, 20000));
			end else begin
				set_config(int'($urandom_range(0, 400000)) - 200000,
					$urandom_range(0, 20000));
			end
			repeat (120) send_random();
		end

		// frozen heading: every step goes north, enough to wrap the position
		set_config(0, DEAD_MAX);
		send_item(shpt_pkg::OP_RESTART, 0, 0);
		repeat (150) begin
			send_item(shpt_pkg::OP_SAMPLE, -1,
				int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN);
			send_item(shpt_pkg::OP_SAMPLE, 1,
				int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN);
		end

		in_valid = 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== step_heading_path_tracker_unit.f =====
hdl/shpt_pkg.sv
hdl/shpt_heading.sv
hdl/step_heading_path_tracker_unit.sv
hdl/shpt_checker.sv
tb/step_track_checker.sv
tb/step_heading_path_tracker_unit_tb.sv
